// File: rtl/core/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every sampled edge.
`define ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mhpq_pkg.sv
// Shared types, constants and the microcode program of the heap queue.
// No dependencies; used by every module of the block but mhpq_ram.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int PRIO_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KID_W    = IDX_W + 1;
  localparam int STEP_W   = 4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KID_W-1:0]  kid_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_e;

  // Datapath action of one microcode step
  typedef enum logic [3:0] {
    U_NOP,
    U_LATCH,
    U_RD_PARENT,
    U_MOVE_UP,
    U_PLACE_INC,
    U_RD_ROOT_LAST,
    U_TAKE_ROOT,
    U_RD_KIDS,
    U_MOVE_DOWN,
    U_PLACE,
    U_EMIT
  } uop_e;

  // Jump condition of one microcode step
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,
    C_REJECT,
    C_IS_EXT,
    C_POS_ZERO,
    C_NOT_LESS,
    C_CNT_ZERO,
    C_NO_BETTER,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t target;
  } uword_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic reject;
    logic is_ext;
    logic pos_zero;
    logic not_less;
    logic cnt_zero;
    logic no_better;
    logic out_busy;
    cnt_t cnt;
  } dp_flags_t;

  localparam step_t ST_IDLE   = step_t'(0);
  localparam step_t ST_DISP   = step_t'(1);
  localparam step_t ST_ROUTE  = step_t'(2);
  localparam step_t ST_UP_RD  = step_t'(3);
  localparam step_t ST_UP_CMP = step_t'(4);
  localparam step_t ST_UP_MOV = step_t'(5);
  localparam step_t ST_UP_END = step_t'(6);
  localparam step_t ST_RD_RL  = step_t'(7);
  localparam step_t ST_TAKE   = step_t'(8);
  localparam step_t ST_DN_RD  = step_t'(9);
  localparam step_t ST_DN_CMP = step_t'(10);
  localparam step_t ST_DN_MOV = step_t'(11);
  localparam step_t ST_DN_END = step_t'(12);
  // Last step, so that falling through wraps back to idle
  localparam step_t ST_EMIT   = '1;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    case (s)
      ST_IDLE:   w = '{op: U_LATCH,        cond: C_NO_IN,     target: ST_IDLE};
      ST_DISP:   w = '{op: U_NOP,          cond: C_REJECT,    target: ST_EMIT};
      ST_ROUTE:  w = '{op: U_NOP,          cond: C_IS_EXT,    target: ST_RD_RL};
      ST_UP_RD:  w = '{op: U_RD_PARENT,    cond: C_POS_ZERO,  target: ST_UP_END};
      ST_UP_CMP: w = '{op: U_NOP,          cond: C_NOT_LESS,  target: ST_UP_END};
      ST_UP_MOV: w = '{op: U_MOVE_UP,      cond: C_ALWAYS,    target: ST_UP_RD};
      ST_UP_END: w = '{op: U_PLACE_INC,    cond: C_ALWAYS,    target: ST_EMIT};
      ST_RD_RL:  w = '{op: U_RD_ROOT_LAST, cond: C_NONE,      target: ST_IDLE};
      ST_TAKE:   w = '{op: U_TAKE_ROOT,    cond: C_CNT_ZERO,  target: ST_EMIT};
      ST_DN_RD:  w = '{op: U_RD_KIDS,      cond: C_NONE,      target: ST_IDLE};
      ST_DN_CMP: w = '{op: U_NOP,          cond: C_NO_BETTER, target: ST_DN_END};
      ST_DN_MOV: w = '{op: U_MOVE_DOWN,    cond: C_ALWAYS,    target: ST_DN_RD};
      ST_DN_END: w = '{op: U_PLACE,        cond: C_ALWAYS,    target: ST_EMIT};
      ST_EMIT:   w = '{op: U_EMIT,         cond: C_OUT_BUSY,  target: ST_EMIT};
      default:   w = '{op: U_NOP,          cond: C_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/mhpq_ram.sv
// Generic simple RAM: one write port, two read ports with registered data.
// No package dependencies.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/core/mhpq_useq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on mhpq_pkg for the program and the control types.
`timescale 1ns / 1ps

module mhpq_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mhpq_pkg::dp_flags_t flags_i,
  output mhpq_pkg::uop_e      op_o,
  output logic                in_ready_o,
  output logic                take_o,
  output mhpq_pkg::step_t     step_o
);

  mhpq_pkg::step_t  upc_q;
  mhpq_pkg::step_t  upc_d;
  mhpq_pkg::uword_t word;
  logic             jump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= mhpq_pkg::ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    word = mhpq_pkg::ucode_rom(upc_q);
    case (word.cond)
      mhpq_pkg::C_NONE:      jump = 1'b0;
      mhpq_pkg::C_ALWAYS:    jump = 1'b1;
      mhpq_pkg::C_NO_IN:     jump = !in_valid_i;
      mhpq_pkg::C_REJECT:    jump = flags_i.reject;
      mhpq_pkg::C_IS_EXT:    jump = flags_i.is_ext;
      mhpq_pkg::C_POS_ZERO:  jump = flags_i.pos_zero;
      mhpq_pkg::C_NOT_LESS:  jump = flags_i.not_less;
      mhpq_pkg::C_CNT_ZERO:  jump = flags_i.cnt_zero;
      mhpq_pkg::C_NO_BETTER: jump = flags_i.no_better;
      mhpq_pkg::C_OUT_BUSY:  jump = flags_i.out_busy;
      default:               jump = 1'b0;
    endcase
    // advance, wrapping from the last step back to idle
    upc_d = jump ? word.target : upc_q + mhpq_pkg::step_t'(1);
  end

  assign op_o       = word.op;
  assign in_ready_o = (upc_q == mhpq_pkg::ST_IDLE);
  assign take_o     = in_ready_o && in_valid_i;
  assign step_o     = upc_q;

endmodule

// File: rtl/core/mhpq_dpath.sv
// Heap datapath: entry store, position and count registers, comparators
// and the result register. Depends on mhpq_pkg and mhpq_ram.
`timescale 1ns / 1ps

module mhpq_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mhpq_pkg::uop_e                op_i,
  input  logic                          take_i,
  input  logic                          req_type_i,
  input  logic [mhpq_pkg::PRIO_W-1:0]   new_priority_i,
  input  logic [mhpq_pkg::HANDLE_W-1:0] new_handle_i,
  input  logic                          m_ready_i,
  output mhpq_pkg::dp_flags_t           flags_o,
  output logic                          m_valid_o,
  output mhpq_pkg::status_e             m_status_o,
  output mhpq_pkg::entry_t              m_entry_o,
  output mhpq_pkg::cnt_t                m_cnt_o
);

  // control state
  mhpq_pkg::cnt_t    cnt_q;
  logic              ov_q;
  // payload
  mhpq_pkg::req_e    req_q;
  mhpq_pkg::entry_t  held_q;
  mhpq_pkg::idx_t    pos_q;
  mhpq_pkg::status_e sts_q;
  mhpq_pkg::entry_t  res_q;
  mhpq_pkg::status_e o_sts_q;
  mhpq_pkg::entry_t  o_ent_q;
  mhpq_pkg::cnt_t    o_cnt_q;

  mhpq_pkg::status_e sts_new;
  mhpq_pkg::idx_t    parent;
  mhpq_pkg::idx_t    last;
  mhpq_pkg::kid_t    kid_l;
  mhpq_pkg::kid_t    kid_r;
  logic              kid_l_ok;
  logic              kid_r_ok;
  logic              less_l;
  logic              less_r;
  logic [mhpq_pkg::PRIO_W-1:0] best_prio;
  logic              out_busy;
  logic              emit;

  logic              ram_we;
  mhpq_pkg::idx_t    ram_waddr;
  mhpq_pkg::entry_t  ram_wdata;
  logic              ram_re;
  mhpq_pkg::idx_t    ram_raddr_a;
  mhpq_pkg::idx_t    ram_raddr_b;
  mhpq_pkg::entry_t  rd_a;
  mhpq_pkg::entry_t  rd_b;

  mhpq_ram #(
    .WIDTH ($bits(mhpq_pkg::entry_t)),
    .DEPTH (mhpq_pkg::CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign parent = (pos_q - mhpq_pkg::idx_t'(1)) >> 1;
  assign last   = mhpq_pkg::idx_t'(cnt_q - mhpq_pkg::cnt_t'(1));
  assign kid_l  = {pos_q, 1'b1};
  assign kid_r  = kid_l + mhpq_pkg::kid_t'(1);

  // left child wins a tie; only a strictly smaller child displaces the node
  assign kid_l_ok  = kid_l < mhpq_pkg::kid_t'(cnt_q);
  assign kid_r_ok  = kid_r < mhpq_pkg::kid_t'(cnt_q);
  assign less_l    = kid_l_ok && (rd_a.prio < held_q.prio);
  assign best_prio = less_l ? rd_a.prio : held_q.prio;
  assign less_r    = kid_r_ok && (rd_b.prio < best_prio);

  assign out_busy = ov_q && !m_ready_i;
  assign emit     = (op_i == mhpq_pkg::U_EMIT) && !out_busy;

  always_comb begin
    if (req_type_i == mhpq_pkg::REQ_INSERT) begin
      sts_new = (cnt_q == mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY)) ?
                mhpq_pkg::STS_FULL : mhpq_pkg::STS_OK;
    end else begin
      sts_new = (cnt_q == '0) ? mhpq_pkg::STS_EMPTY : mhpq_pkg::STS_OK;
    end
  end

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = held_q;
    ram_re      = 1'b0;
    ram_raddr_a = parent;
    ram_raddr_b = kid_r[mhpq_pkg::IDX_W-1:0];
    case (op_i)
      mhpq_pkg::U_RD_PARENT: begin
        ram_re = 1'b1;
      end
      mhpq_pkg::U_MOVE_UP: begin
        ram_we    = 1'b1;
        ram_wdata = rd_a;
      end
      mhpq_pkg::U_PLACE_INC, mhpq_pkg::U_PLACE: begin
        ram_we = 1'b1;
      end
      mhpq_pkg::U_RD_ROOT_LAST: begin
        ram_re      = 1'b1;
        ram_raddr_a = '0;
        ram_raddr_b = last;
      end
      mhpq_pkg::U_RD_KIDS: begin
        ram_re      = 1'b1;
        ram_raddr_a = kid_l[mhpq_pkg::IDX_W-1:0];
      end
      mhpq_pkg::U_MOVE_DOWN: begin
        ram_we    = 1'b1;
        ram_wdata = less_r ? rd_b : rd_a;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      case (op_i)
        mhpq_pkg::U_PLACE_INC:    cnt_q <= cnt_q + mhpq_pkg::cnt_t'(1);
        mhpq_pkg::U_RD_ROOT_LAST: cnt_q <= cnt_q - mhpq_pkg::cnt_t'(1);
        default:                  cnt_q <= cnt_q;
      endcase
      if (emit) begin
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((op_i == mhpq_pkg::U_LATCH) && take_i) begin
      req_q  <= mhpq_pkg::req_e'(req_type_i);
      held_q <= '{prio: new_priority_i, handle: new_handle_i};
      pos_q  <= cnt_q[mhpq_pkg::IDX_W-1:0];
      sts_q  <= sts_new;
      res_q  <= '0;
    end
    case (op_i)
      mhpq_pkg::U_MOVE_UP: begin
        pos_q <= parent;
      end
      mhpq_pkg::U_TAKE_ROOT: begin
        res_q  <= rd_a;
        held_q <= rd_b;
        pos_q  <= '0;
      end
      mhpq_pkg::U_MOVE_DOWN: begin
        pos_q <= less_r ? kid_r[mhpq_pkg::IDX_W-1:0] : kid_l[mhpq_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
    if (emit) begin
      o_sts_q <= sts_q;
      o_ent_q <= res_q;
      o_cnt_q <= cnt_q;
    end
  end

  assign flags_o = '{
    reject:    (sts_q != mhpq_pkg::STS_OK),
    is_ext:    (req_q == mhpq_pkg::REQ_EXTRACT),
    pos_zero:  (pos_q == '0),
    not_less:  !(held_q.prio < rd_a.prio),
    cnt_zero:  (cnt_q == '0),
    no_better: !(less_l || less_r),
    out_busy:  out_busy,
    cnt:       cnt_q
  };

  assign m_valid_o  = ov_q;
  assign m_status_o = o_sts_q;
  assign m_entry_o  = o_ent_q;
  assign m_cnt_o    = o_cnt_q;

endmodule

// File: rtl/core/min_heap_priority_queue_core.sv
// Binary min-heap priority queue, one request at a time under a microcode sequencer.
// A rejected request goes straight to the result. An insert moves up from the new leaf; an
// extract reads root and last entry, takes the root and, unless the heap is then empty, moves
// down. Each level moved takes a read, a compare and a write step.
// The next request is taken at idle, even while a result waits; a stalled result holds the
// program. Reset (rst_ni low, async) empties the heap, drops the output and idles the sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_heap_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // new_priority, new_handle
  input  logic [0:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_priority, out_handle, entry_count, zero pad
  output logic [1:0]  m_axis_tuser   // status
);

  localparam int OUT_RAW_W = mhpq_pkg::PRIO_W + mhpq_pkg::HANDLE_W + mhpq_pkg::CNT_W;

  mhpq_pkg::dp_flags_t flags;
  mhpq_pkg::uop_e      op;
  mhpq_pkg::step_t     step;
  logic                take;
  mhpq_pkg::status_e   out_sts;
  mhpq_pkg::entry_t    out_ent;
  mhpq_pkg::cnt_t      out_cnt;

  mhpq_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .flags_i    (flags),
    .op_o       (op),
    .in_ready_o (s_axis_tready),
    .take_o     (take),
    .step_o     (step)
  );

  mhpq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .take_i         (take),
    .req_type_i     (s_axis_tuser[0]),
    .new_priority_i (s_axis_tdata[mhpq_pkg::PRIO_W-1:0]),
    .new_handle_i   (s_axis_tdata[mhpq_pkg::PRIO_W +: mhpq_pkg::HANDLE_W]),
    .m_ready_i      (m_axis_tready),
    .flags_o        (flags),
    .m_valid_o      (m_axis_tvalid),
    .m_status_o     (out_sts),
    .m_entry_o      (out_ent),
    .m_cnt_o        (out_cnt)
  );

  assign m_axis_tuser = out_sts;
  assign m_axis_tdata = {{($bits(m_axis_tdata) - OUT_RAW_W){1'b0}},
                         out_cnt, out_ent.handle, out_ent.prio};

  `ASSERT_HOLDS(a_cnt_range, flags.cnt <= mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY), "count above capacity")

  `ASSERT_NEXT(a_take_dispatch, s_axis_tvalid && s_axis_tready, step == mhpq_pkg::ST_DISP, "transfer did not start the program")

  `ASSERT_IMPLIES(a_full_count, m_axis_tvalid && (out_sts == mhpq_pkg::STS_FULL), out_cnt == mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY), "full status with spare room")

  `ASSERT_IMPLIES(a_empty_zero, m_axis_tvalid && (out_sts == mhpq_pkg::STS_EMPTY), (out_cnt == '0) && (out_ent == '0), "empty status with data or count")

endmodule
